// ----- src/kme_pkg.sv -----
// ----------------------------------------------------------------------------
// kme_pkg: shared types and constants of the key matrix scanner
// Row roles, history patterns and the per-row status handed to the merge stage.
// ----------------------------------------------------------------------------
package kme_pkg;

   localparam int ROWS    = 8;
   localparam int NUM_EVT = 6;
   localparam int EVT_W   = 3;

   localparam logic [7:0] PRESS_PAT   = 8'h80;
   localparam logic [7:0] RELEASE_PAT = 8'h01;
   localparam logic [7:0] PHASE_MASK  = 8'h03;
   localparam logic [1:0] PHASE_EDGE  = 2'b10;
   localparam logic [1:0] PHASE_LOW   = 2'b00;

   localparam logic KIND_BUTTON  = 1'b0;
   localparam logic KIND_ENCODER = 1'b1;

   localparam logic signed [1:0] VAL_PLUS  = 2'sb01;
   localparam logic signed [1:0] VAL_ZERO  = 2'sb00;
   localparam logic signed [1:0] VAL_MINUS = 2'sb11;

   // event slots in report order: buttons 0,3,6,7 then encoders A=1 and A=4
   localparam int NUM_BTN = 4;
   localparam int NUM_ENC = 2;
   localparam logic [2:0] BTN_ROW   [NUM_BTN] = '{3'd0, 3'd3, 3'd6, 3'd7};
   localparam logic [2:0] ENC_A_ROW [NUM_ENC] = '{3'd1, 3'd4};
   localparam logic [2:0] ENC_B_ROW [NUM_ENC] = '{3'd2, 3'd5};

   typedef logic [ROWS-1:0][7:0] hist_row_type;

   typedef struct packed {
      logic       press;
      logic       release_hit;
      logic [1:0] phase;
   } lane_stat_type;

   typedef struct packed {
      logic                            valid;
      logic [3:0]                      column;
      logic [ROWS-1:0][$bits(lane_stat_type)-1:0] stat;
   } scan_word_type;

endpackage

// ----- src/key_matrix_edge_and_encoder_scan.sv -----
// ----------------------------------------------------------------------------
// key_matrix_edge_and_encoder_scan: key matrix scanner with encoder decode
// Keeps an 8-poll history per switch and reports button and encoder events.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one scanned column word: its index and the 8 raw row levels.
//   rsp_* returns the events the column causes, buttons (rows 0,3,6,7) first,
//   then the encoders on rows (1,2) and (4,5); rsp_last_event marks the final
//   word of a column. A quiet column or one at or above NUM_COLUMNS returns
//   nothing. Each word is accepted when valid is high and stall is low.
//   An accepted column word is registered in stage 1, then in the merge pending
//   set, then each event word in the output register. While rsp_stall is low,
//   the merge stage sends one event word a cycle, at most 6 per column; a new
//   column is taken every cycle while columns raise at most one event.
//   The history store is a memory of NUM_COLUMNS rows of 64 bits with a
//   registered read; a per-row valid flag makes never-written rows read zero.
//   Reset clears the flags and empties the pipeline at once, no sweep.
//   When rsp_stall is high the held word stays put and the pipeline backs up
//   to req_stall once the merge stage holds pending events.
// ----------------------------------------------------------------------------
module key_matrix_edge_and_encoder_scan #(
   parameter int NUM_COLUMNS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [3:0]        req_column_index,
   input  logic [7:0]        req_row_bits,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_event_kind,
   output logic [6:0]        rsp_switch_id,
   output logic signed [1:0] rsp_event_value,
   output logic              rsp_last_event
);
   import kme_pkg::*;

   localparam int AW = (NUM_COLUMNS > 1) ? $clog2(NUM_COLUMNS) : 1;
   localparam int IW = ((AW > 4) ? AW : 4) + 1;

   hist_row_type            hist_mem [NUM_COLUMNS];
   logic [NUM_COLUMNS-1:0]  col_vld_ff;

   logic [IW-1:0]           col_ext;
   logic [AW-1:0]           req_addr;
   logic                    in_range, req_take;

   logic                    s1_valid_ff, s1_valid_in;
   logic [3:0]              s1_col_ff;
   logic [AW-1:0]           s1_addr_ff;
   logic [7:0]              s1_rows_ff;
   hist_row_type            rd_ff, byp_ff, cur_hist, new_hist;
   logic                    vld_rd_ff, byp_sel_ff;
   logic                    s1_adv, merge_ready;
   lane_stat_type           stat [ROWS];
   scan_word_type           scan;

   assign col_ext  = IW'(req_column_index);
   assign req_addr = col_ext[AW-1:0];
   assign in_range = col_ext < IW'(NUM_COLUMNS);

   assign s1_adv    = s1_valid_ff && merge_ready;
   assign req_stall = s1_valid_ff && !merge_ready;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take) begin
         s1_valid_in = in_range;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         col_vld_ff  <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (s1_adv) begin
            col_vld_ff[s1_addr_ff] <= 1'b1;
         end
      end
   end

   // history memory: one row per column, written as the column leaves stage 1
   always_ff @(posedge clock) begin
      if (s1_adv) begin
         hist_mem[s1_addr_ff] <= new_hist;
      end
      if (req_take && in_range) begin
         rd_ff      <= hist_mem[req_addr];
         vld_rd_ff  <= col_vld_ff[req_addr];
         // same column written this edge: forward the fresh row
         byp_sel_ff <= s1_valid_ff && (s1_addr_ff == req_addr);
         byp_ff     <= new_hist;
         s1_col_ff  <= req_column_index;
         s1_addr_ff <= req_addr;
         s1_rows_ff <= req_row_bits;
      end
   end

   assign cur_hist = byp_sel_ff ? byp_ff : (vld_rd_ff ? rd_ff : '0);

   for (genvar r = 0; r < ROWS; r++) begin : g_lane
      kme_lane u_lane (
         .level    (s1_rows_ff[r]),
         .hist_old (cur_hist[r]),
         .hist_new (new_hist[r]),
         .stat     (stat[r])
      );
   end

   always_comb begin
      scan.valid  = s1_valid_ff;
      scan.column = s1_col_ff;
      for (int r = 0; r < ROWS; r++) begin
         scan.stat[r] = stat[r];
      end
   end

   kme_merge u_merge (
      .clock           (clock),
      .reset           (reset),
      .scan            (scan),
      .scan_ready      (merge_ready),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_event_kind  (rsp_event_kind),
      .rsp_switch_id   (rsp_switch_id),
      .rsp_event_value (rsp_event_value),
      .rsp_last_event  (rsp_last_event)
   );

endmodule

// ----- src/kme_lane.sv -----
// ----------------------------------------------------------------------------
// kme_lane: one switch of the scanned column
// Shifts the new level into the switch history and flags the edge patterns.
// ----------------------------------------------------------------------------
module kme_lane (
   input  logic                  level,
   input  logic [7:0]            hist_old,
   output logic [7:0]            hist_new,
   output kme_pkg::lane_stat_type stat
);
   import kme_pkg::*;

   always_comb begin
      hist_new         = {hist_old[6:0], level};
      stat.press       = (hist_new == PRESS_PAT);
      stat.release_hit = (hist_new == RELEASE_PAT);
      stat.phase       = 2'(hist_new & PHASE_MASK);
   end

endmodule

// ----- src/kme_merge.sv -----
// ----------------------------------------------------------------------------
// kme_merge: event merge and output stage
// Builds the column's events from lane flags, one word a cycle if not stalled.
// ----------------------------------------------------------------------------
module kme_merge (
   input  logic                  clock,
   input  logic                  reset,
   input  kme_pkg::scan_word_type scan,
   output logic                  scan_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_event_kind,
   output logic [6:0]            rsp_switch_id,
   output logic signed [1:0]     rsp_event_value,
   output logic                  rsp_last_event
);
   import kme_pkg::*;

   logic [NUM_EVT-1:0]     pend_ff, pend_in;
   logic [3:0]             col_ff, col_in;
   logic signed [1:0]      val_ff [NUM_EVT];
   logic signed [1:0]      val_in [NUM_EVT];
   logic [NUM_EVT-1:0]     new_mask;
   logic [NUM_EVT-1:0]     pick_oh, remaining;
   logic [EVT_W-1:0]       pick_idx;
   logic                   found, out_free, load, take;
   lane_stat_type          st [ROWS];
   lane_stat_type          sa, sb;
   logic                   up, dn;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   kind_ff;
   logic [6:0]             id_ff;
   logic signed [1:0]      value_ff;
   logic                   last_ff;

   always_comb begin
      for (int r = 0; r < ROWS; r++) begin
         st[r] = lane_stat_type'(scan.stat[r]);
      end
      new_mask = '0;
      for (int i = 0; i < NUM_EVT; i++) begin
         val_in[i] = val_ff[i];
      end
      for (int i = 0; i < NUM_BTN; i++) begin
         new_mask[i] = st[BTN_ROW[i]].press | st[BTN_ROW[i]].release_hit;
      end
      for (int j = 0; j < NUM_ENC; j++) begin
         sa = st[ENC_A_ROW[j]];
         sb = st[ENC_B_ROW[j]];
         up = (sb.phase == PHASE_EDGE) && (sa.phase == PHASE_LOW);
         dn = (sa.phase == PHASE_EDGE) && (sb.phase == PHASE_LOW);
         new_mask[NUM_BTN+j] = up | dn;
      end

      // lowest pending slot goes out next
      found    = 1'b0;
      pick_oh  = '0;
      pick_idx = '0;
      for (int i = 0; i < NUM_EVT; i++) begin
         if (pend_ff[i] && !found) begin
            found      = 1'b1;
            pick_oh[i] = 1'b1;
            pick_idx   = EVT_W'(i);
         end
      end
      remaining = pend_ff & ~pick_oh;

      out_free   = !rsp_valid_ff || !rsp_stall;
      load       = found && out_free;
      scan_ready = (pend_ff == '0) || (load && (remaining == '0));
      take       = scan.valid && scan_ready;

      pend_in = pend_ff;
      col_in  = col_ff;
      if (take) begin
         pend_in = new_mask;
         col_in  = scan.column;
         for (int i = 0; i < NUM_BTN; i++) begin
            val_in[i] = st[BTN_ROW[i]].press ? VAL_PLUS : VAL_ZERO;
         end
         for (int j = 0; j < NUM_ENC; j++) begin
            val_in[NUM_BTN+j] = (st[ENC_B_ROW[j]].phase == PHASE_EDGE) ? VAL_PLUS : VAL_MINUS;
         end
      end else if (load) begin
         pend_in = remaining;
      end

      rsp_valid_in = out_free ? load : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      col_ff <= col_in;
      for (int i = 0; i < NUM_EVT; i++) begin
         val_ff[i] <= val_in[i];
      end
      if (load) begin
         kind_ff  <= (pick_idx < EVT_W'(NUM_BTN)) ? KIND_BUTTON : KIND_ENCODER;
         id_ff    <= (pick_idx < EVT_W'(NUM_BTN))
                     ? {col_ff, BTN_ROW[2'(pick_idx)]}
                     : {col_ff, ENC_A_ROW[1'(pick_idx - EVT_W'(NUM_BTN))]};
         value_ff <= val_ff[pick_idx];
         last_ff  <= (remaining == '0);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_event_kind  = kind_ff;
   assign rsp_switch_id   = id_ff;
   assign rsp_event_value = value_ff;
   assign rsp_last_event  = last_ff;

endmodule

// ----- src/kme_checker.sv -----
// ----------------------------------------------------------------------------
// kme_checker: port-level checks of the key matrix scanner
// Checks both channels hold under stall and that event words are legal.
// ----------------------------------------------------------------------------
module kme_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic [3:0]        req_column_index,
   input logic [7:0]        req_row_bits,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic              rsp_event_kind,
   input logic [6:0]        rsp_switch_id,
   input logic signed [1:0] rsp_event_value,
   input logic              rsp_last_event
);
   import kme_pkg::*;

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_column_index)
         && $stable(req_row_bits))
      else $error("column word changed while stalled");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_event_kind)
         && $stable(rsp_switch_id) && $stable(rsp_event_value)
         && $stable(rsp_last_event))
      else $error("event word changed while stalled");

   a_btn_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_kind == KIND_BUTTON |->
         rsp_switch_id[2:0] == BTN_ROW[0] || rsp_switch_id[2:0] == BTN_ROW[1]
         || rsp_switch_id[2:0] == BTN_ROW[2] || rsp_switch_id[2:0] == BTN_ROW[3])
      else $error("button event on a non-button row");

   a_btn_val: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_kind == KIND_BUTTON |->
         rsp_event_value == VAL_PLUS || rsp_event_value == VAL_ZERO)
      else $error("button event with illegal value");

   a_enc: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_kind == KIND_ENCODER |->
         (rsp_switch_id[2:0] == ENC_A_ROW[0] || rsp_switch_id[2:0] == ENC_A_ROW[1])
         && (rsp_event_value == VAL_PLUS || rsp_event_value == VAL_MINUS))
      else $error("malformed encoder event");

endmodule

bind key_matrix_edge_and_encoder_scan kme_checker u_kme_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .req_column_index (req_column_index),
   .req_row_bits     (req_row_bits),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_event_kind   (rsp_event_kind),
   .rsp_switch_id    (rsp_switch_id),
   .rsp_event_value  (rsp_event_value),
   .rsp_last_event   (rsp_last_event)
);
